[rtl/cbt_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the cubic B-spline tessellator.
// No dependencies; every rtl file refers to it by scoped names.
package cbt_pkg;

  // biased coordinate (value + 2^31), always unsigned 32 bits
  localparam int unsigned CW  = 32;
  localparam int unsigned NW  = 6;   // segment count
  localparam int unsigned TW  = 17;  // curve parameter t in Q16, up to 1.0
  localparam int unsigned SQW = 33;  // t^2 in Q32
  localparam int unsigned CBW = 49;  // t^3 in Q48
  localparam int unsigned WW  = 51;  // blend weights in Q48, below 6.0
  localparam int unsigned WLW = 26;  // low slice of a weight per multiply
  localparam int unsigned PW  = 58;  // partial product
  localparam int unsigned AW  = 83;  // blend accumulator
  localparam int unsigned QW  = 44;  // accumulator top, padded to nibbles
  localparam int unsigned VW  = 24;  // vertex coordinate, Q8

  localparam logic [TW-1:0] T_ONE    = 17'h1_0000;
  localparam logic [AW-1:0] ROUND_OF = 83'h3 << 40;
  localparam logic [QW-1:0] Q_BIAS   = 44'h080_0000_0000;
  localparam logic [QW-1:0] Q_LO     = 44'h07F_FF80_0000;
  localparam logic [QW-1:0] Q_HI     = 44'h080_007F_FFFF;

  typedef logic [CW-1:0] coord_t;
  typedef coord_t [2:0] point_t;      // [0]=x [1]=y [2]=z
  typedef point_t [3:0] span_pts_t;   // [0] oldest .. [3] newest

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

[rtl/cubic_bspline_tessellator.sv]
`timescale 1ns / 1ps
// Top level of the uniform cubic B-spline tessellator: config register,
// front end, span queue and evaluator. Depends on cbt_pkg and all cbt_* modules.
//
//  channel   direction  handshake                   payload
//  s_axis    in         s_axis_tvalid/tready        tdata {z,y,x}, tuser new_curve
//  m_axis    out        m_axis_tvalid/tready        tdata {z,y,x} Q8, tlast span_end
//  cfg       in         cfg_valid_i/cfg_ready_o     segments_per_span
//
// For a closing point the evaluator pops the span, runs a 17-step divide for
// the t step and a start state, then per vertex the square, cube and weight
// states, per coordinate a multiply-accumulate over the one 26x32 multiplier
// and 11 divide-by-3 digits, and the output state. Points that close no span
// only enter the window. The front end accepts while the two-entry span queue
// has room; the output register holds a vertex while m_axis_tready is low.
// Reset is asynchronous; no clearing pass.
module cubic_bspline_tessellator #(
  parameter int COORD_BITS   = 16,
  parameter int MAX_SEGMENTS = 63
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // point_x, point_y, point_z
  input  logic [((3*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
  // new_curve
  input  logic                              s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // vertex_x, vertex_y, vertex_z
  output logic [3*cbt_pkg::VW-1:0]          m_axis_tdata,
  output logic                              m_axis_tlast,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [cbt_pkg::NW-1:0]            cfg_data_i
);

  logic [cbt_pkg::NW-1:0] seg_q;
  cbt_pkg::fifo_stat_t    fstat;
  cbt_pkg::span_pts_t     push_span, pop_span;
  logic                   push, pop;
  logic [cbt_pkg::VW-1:0] vx, vy, vz;

  // hold the segment count
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q <= cbt_pkg::NW'(10);
    end else if (cfg_valid_i) begin
      seg_q <= cfg_data_i;
    end
  end

  cbt_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .point_x_i   (s_axis_tdata[COORD_BITS-1:0]),
    .point_y_i   (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
    .point_z_i   (s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS]),
    .new_curve_i (s_axis_tuser),
    .fifo_stat_i (fstat),
    .push_o      (push),
    .span_o      (push_span)
  );

  cbt_job_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .span_i (push_span),
    .pop_i  (pop),
    .span_o (pop_span),
    .stat_o (fstat)
  );

  cbt_eval #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_eval (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .seg_cfg_i   (seg_q),
    .fifo_stat_i (fstat),
    .span_i      (pop_span),
    .pop_o       (pop),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .vertex_x_o  (vx),
    .vertex_y_o  (vy),
    .vertex_z_o  (vz),
    .span_end_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {vz, vy, vx};

endmodule

[rtl/cbt_front.sv]
`timescale 1ns / 1ps
// Front end: takes control points, keeps the three-point window and
// issues one span request per closing point. Depends on cbt_pkg.
module cbt_front #(
  parameter int COORD_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [COORD_BITS-1:0] point_x_i,
  input  logic [COORD_BITS-1:0] point_y_i,
  input  logic [COORD_BITS-1:0] point_z_i,
  input  logic                  new_curve_i,
  input  cbt_pkg::fifo_stat_t   fifo_stat_i,
  output logic                  push_o,
  output cbt_pkg::span_pts_t    span_o
);

  cbt_pkg::point_t win_q [3];
  cbt_pkg::point_t pnt;
  logic [1:0]      seen_q;
  logic            take;

  // sign extend and bias each coordinate by 2^31
  always_comb begin
    pnt[0] = cbt_pkg::coord_t'(32'(signed'(point_x_i))) ^ 32'h8000_0000;
    pnt[1] = cbt_pkg::coord_t'(32'(signed'(point_y_i))) ^ 32'h8000_0000;
    pnt[2] = cbt_pkg::coord_t'(32'(signed'(point_z_i))) ^ 32'h8000_0000;
  end

  assign in_ready_o = ~fifo_stat_i.full;
  assign take       = in_valid_i & in_ready_o;
  assign push_o     = take & ~new_curve_i & (seen_q == 2'd3);

  always_comb begin
    span_o[0] = win_q[0];
    span_o[1] = win_q[1];
    span_o[2] = win_q[2];
    span_o[3] = pnt;
  end

  // count points held; a new curve restarts at one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 2'd0;
    end else if (take) begin
      if (new_curve_i) begin
        seen_q <= 2'd1;
      end else if (seen_q != 2'd3) begin
        seen_q <= seen_q + 2'd1;
      end
    end
  end

  // shift the window
  always_ff @(posedge clk_i) begin
    if (take) begin
      win_q[0] <= win_q[1];
      win_q[1] <= win_q[2];
      win_q[2] <= pnt;
    end
  end

endmodule

[rtl/cbt_job_fifo.sv]
`timescale 1ns / 1ps
// Two-entry queue of span requests between front and back end.
// Depends on cbt_pkg.
module cbt_job_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  cbt_pkg::span_pts_t   span_i,
  input  logic                 pop_i,
  output cbt_pkg::span_pts_t   span_o,
  output cbt_pkg::fifo_stat_t  stat_o
);

  cbt_pkg::span_pts_t mem_q [2];
  logic               wr_q, rd_q;
  logic [1:0]         cnt_q;

  assign stat_o.full  = (cnt_q == 2'd2);
  assign stat_o.empty = (cnt_q == 2'd0);
  assign span_o       = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= span_i;
    end
  end

  // advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop_i) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

[rtl/cbt_eval.sv]
`timescale 1ns / 1ps
// Back end: steps t across a span, forms the four blend weights and
// evaluates x, y, z with a shared multiplier and a radix-16 divide by 3.
// Depends on cbt_pkg.
module cbt_eval #(
  parameter int MAX_SEGMENTS = 63
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [cbt_pkg::NW-1:0] seg_cfg_i,
  input  cbt_pkg::fifo_stat_t    fifo_stat_i,
  input  cbt_pkg::span_pts_t     span_i,
  output logic                   pop_o,
  output logic                   m_valid_o,
  input  logic                   m_ready_i,
  output logic [cbt_pkg::VW-1:0] vertex_x_o,
  output logic [cbt_pkg::VW-1:0] vertex_y_o,
  output logic [cbt_pkg::VW-1:0] vertex_z_o,
  output logic                   span_end_o
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_NDIV, ST_VSTART, ST_SQ, ST_CUBE, ST_WGT, ST_MAC, ST_DIV3, ST_OUT
  } state_e;

  state_e                    state_q;
  cbt_pkg::span_pts_t        job_q;
  logic [cbt_pkg::NW-1:0]    n_q, n_eff;
  logic [cbt_pkg::TW-1:0]    dvd_q, q0_q, t_q, s_val;
  logic [cbt_pkg::NW-1:0]    nrem_q, tr_q, i_q;
  logic [4:0]                bit_cnt_q;
  logic [cbt_pkg::NW:0]      rem_sh, tr_sum;
  logic [cbt_pkg::SQW-1:0]   t2_q, s2_q;
  logic [cbt_pkg::CBW-1:0]   t3_q, s3_q;
  logic [cbt_pkg::WW-1:0]    w_q [4];
  logic [51:0]               w1_d, w2_d;
  logic [1:0]                coord_q;
  logic [3:0]                k_q;
  logic [cbt_pkg::WW-1:0]    w_sel;
  logic [cbt_pkg::WLW-1:0]   mul_a;
  logic [cbt_pkg::PW-1:0]    prod_q;
  logic                      prod_hi_q;
  logic [cbt_pkg::AW-1:0]    acc_q, acc_d;
  logic [cbt_pkg::QW-1:0]    x3_q, quo_q, quo_d;
  logic [1:0]                rem3_q, rem3_d;
  logic [3:0]                dcnt_q, qd;
  logic [5:0]                r6;
  logic [11:0]               r6_mul;
  logic [cbt_pkg::VW-1:0]    vtx_q [3];
  logic [cbt_pkg::VW-1:0]    sat_v;
  logic                      m_valid_q, m_last_q;
  logic [cbt_pkg::VW-1:0]    m_x_q, m_y_q, m_z_q;
  logic                      out_free;

  // clamp the segment count into 1..MAX_SEGMENTS
  always_comb begin
    if (seg_cfg_i == '0) begin
      n_eff = cbt_pkg::NW'(1);
    end else if (seg_cfg_i > cbt_pkg::NW'(MAX_SEGMENTS)) begin
      n_eff = cbt_pkg::NW'(MAX_SEGMENTS);
    end else begin
      n_eff = seg_cfg_i;
    end
  end

  // datapath helpers
  always_comb begin
    rem_sh = {nrem_q, dvd_q[cbt_pkg::TW-1]};
    tr_sum = {1'b0, tr_q} + {1'b0, nrem_q};
    s_val  = cbt_pkg::T_ONE - t_q;
    w1_d   = (52'd4 << 48) + 52'(t3_q) * 52'd3 - (52'(t2_q) << 16) * 52'd6;
    w2_d   = (52'd1 << 48) + (52'(t_q) << 32) * 52'd3 + (52'(t2_q) << 16) * 52'd3
           - 52'(t3_q) * 52'd3;
    w_sel  = w_q[k_q[2:1]];
    mul_a  = k_q[0] ? {1'b0, w_sel[cbt_pkg::WW-1:cbt_pkg::WLW]}
                    : w_sel[cbt_pkg::WLW-1:0];
    acc_d  = acc_q + (prod_hi_q ? (cbt_pkg::AW'(prod_q) << cbt_pkg::WLW)
                                : cbt_pkg::AW'(prod_q));
    r6     = {rem3_q, x3_q[cbt_pkg::QW-1 -: 4]};
    r6_mul = 12'(r6) * 12'd43;
    qd     = r6_mul[10:7];
    rem3_d = 2'(r6 - 6'(qd) * 6'd3);
    quo_d  = {quo_q[cbt_pkg::QW-5:0], qd};
    if (quo_d < cbt_pkg::Q_LO) begin
      sat_v = cbt_pkg::VW'(cbt_pkg::Q_LO - cbt_pkg::Q_BIAS);
    end else if (quo_d > cbt_pkg::Q_HI) begin
      sat_v = cbt_pkg::VW'(cbt_pkg::Q_HI - cbt_pkg::Q_BIAS);
    end else begin
      sat_v = cbt_pkg::VW'(quo_d - cbt_pkg::Q_BIAS);
    end
  end

  assign out_free = ~m_valid_q | m_ready_i;
  assign pop_o    = (state_q == ST_IDLE) & ~fifo_stat_i.empty;

  // span sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      // drop the vertex once taken, unless a new one replaces it
      if (m_valid_q && m_ready_i && (state_q != ST_OUT)) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (!fifo_stat_i.empty) begin
            job_q     <= span_i;
            n_q       <= n_eff;
            dvd_q     <= cbt_pkg::T_ONE;
            nrem_q    <= '0;
            q0_q      <= '0;
            bit_cnt_q <= 5'd16;
            state_q   <= ST_NDIV;
          end
        end
        // restoring divide of 2^16 by N, one quotient bit per cycle
        ST_NDIV: begin
          dvd_q <= dvd_q << 1;
          if (rem_sh >= {1'b0, n_q}) begin
            nrem_q <= cbt_pkg::NW'(rem_sh - {1'b0, n_q});
            q0_q   <= {q0_q[cbt_pkg::TW-2:0], 1'b1};
          end else begin
            nrem_q <= cbt_pkg::NW'(rem_sh);
            q0_q   <= {q0_q[cbt_pkg::TW-2:0], 1'b0};
          end
          bit_cnt_q <= bit_cnt_q - 5'd1;
          if (bit_cnt_q == 5'd0) begin
            state_q <= ST_VSTART;
          end
        end
        ST_VSTART: begin
          i_q     <= '0;
          t_q     <= '0;
          tr_q    <= '0;
          state_q <= ST_SQ;
        end
        ST_SQ: begin
          t2_q    <= cbt_pkg::SQW'(t_q) * cbt_pkg::SQW'(t_q);
          s2_q    <= cbt_pkg::SQW'(s_val) * cbt_pkg::SQW'(s_val);
          state_q <= ST_CUBE;
        end
        ST_CUBE: begin
          t3_q    <= cbt_pkg::CBW'(t2_q * 49'(t_q));
          s3_q    <= cbt_pkg::CBW'(s2_q * 49'(s_val));
          state_q <= ST_WGT;
        end
        ST_WGT: begin
          w_q[0]  <= cbt_pkg::WW'(s3_q);
          w_q[1]  <= cbt_pkg::WW'(w1_d);
          w_q[2]  <= cbt_pkg::WW'(w2_d);
          w_q[3]  <= cbt_pkg::WW'(t3_q);
          coord_q <= 2'd0;
          k_q     <= 4'd0;
          acc_q   <= cbt_pkg::ROUND_OF;
          state_q <= ST_MAC;
        end
        // one partial product per cycle, added to the accumulator in the cycle after
        ST_MAC: begin
          if (k_q != 4'd8) begin
            prod_q    <= cbt_pkg::PW'(mul_a) * cbt_pkg::PW'(job_q[k_q[2:1]][coord_q]);
            prod_hi_q <= k_q[0];
          end
          if (k_q != 4'd0) begin
            acc_q <= acc_d;
          end
          k_q <= k_q + 4'd1;
          if (k_q == 4'd8) begin
            x3_q    <= {2'b00, acc_d[cbt_pkg::AW-1:41]};
            quo_q   <= '0;
            rem3_q  <= 2'd0;
            dcnt_q  <= 4'd10;
            state_q <= ST_DIV3;
          end
        end
        // divide by 3, one hex digit per cycle
        ST_DIV3: begin
          x3_q   <= x3_q << 4;
          quo_q  <= quo_d;
          rem3_q <= rem3_d;
          dcnt_q <= dcnt_q - 4'd1;
          if (dcnt_q == 4'd0) begin
            vtx_q[coord_q] <= sat_v;
            if (coord_q == 2'd2) begin
              state_q <= ST_OUT;
            end else begin
              coord_q <= coord_q + 2'd1;
              k_q     <= 4'd0;
              acc_q   <= cbt_pkg::ROUND_OF;
              state_q <= ST_MAC;
            end
          end
        end
        ST_OUT: begin
          if (out_free) begin
            m_valid_q <= 1'b1;
            m_x_q     <= vtx_q[0];
            m_y_q     <= vtx_q[1];
            m_z_q     <= vtx_q[2];
            m_last_q  <= (i_q == n_q);
            if (i_q == n_q) begin
              state_q <= ST_IDLE;
            end else begin
              i_q <= i_q + cbt_pkg::NW'(1);
              if (tr_sum >= {1'b0, n_q}) begin
                tr_q <= cbt_pkg::NW'(tr_sum - {1'b0, n_q});
                t_q  <= t_q + q0_q + cbt_pkg::TW'(1);
              end else begin
                tr_q <= cbt_pkg::NW'(tr_sum);
                t_q  <= t_q + q0_q;
              end
              state_q <= ST_SQ;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_valid_o  = m_valid_q;
  assign vertex_x_o = m_x_q;
  assign vertex_y_o = m_y_q;
  assign vertex_z_o = m_z_q;
  assign span_end_o = m_last_q;

  // the last vertex of a span lands exactly on t = 1
  a_last_t_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && i_q == n_q) |-> (t_q == cbt_pkg::T_ONE))
    else $error("t does not reach one at span end");

  // the step remainder stays below N while vertices are produced
  a_tr_below_n: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SQ || state_q == ST_CUBE || state_q == ST_WGT || state_q == ST_OUT)
    |-> (tr_q < n_q))
    else $error("t step remainder out of range");

  // divide-by-3 remainder is a valid digit
  a_rem3: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV3) |-> (rem3_q != 2'd3))
    else $error("divide by 3 remainder out of range");

  // every coordinate starts from the rounding offset
  a_acc_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MAC && k_q == 4'd0) |-> (acc_q == cbt_pkg::ROUND_OF))
    else $error("accumulator not seeded");

endmodule
